// File: hdl/bgp_message_prefix_counter_macros.svh
// assertion macros for the bgp message prefix counter checker
`ifndef BGP_MESSAGE_PREFIX_COUNTER_MACROS_SVH
`define BGP_MESSAGE_PREFIX_COUNTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define BMPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BMPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/bmpc_pkg.sv
// types, constants and helpers shared by the bgp message prefix counter
package bmpc_pkg;

    localparam logic [15:0] MAX_LEN      = 16'd4096;
    localparam logic [15:0] MIN_LEN      = 16'd19;
    localparam logic [15:0] EOR_LEN      = 16'd23;
    localparam logic [15:0] LEN_HI_POS   = 16'd16;
    localparam logic [15:0] LEN_LO_POS   = 16'd17;
    localparam logic [15:0] TYPE_POS     = 16'd18;
    localparam logic [7:0]  TYPE_MIN     = 8'd1;
    localparam logic [7:0]  TYPE_MAX     = 8'd4;
    localparam logic [7:0]  TYPE_UPDATE  = 8'd2;
    localparam logic [12:0] TALLY_MAX    = 13'h1FFF;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_WLEN,
        PH_WSKIP,
        PH_PLEN,
        PH_PSKIP,
        PH_NLRI
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK,
        ST_ILLEGAL_TYPE,
        ST_BAD_LENGTH,
        ST_OVERRUN
    } t_status;

    typedef struct packed {
        logic [7:0]  message_type;
        logic [15:0] message_length;
        logic [12:0] prefix_total;
        logic        end_of_rib;
        t_status     status;
    } t_result;

    // number of address bytes that follow an nlri prefix-length byte
    function automatic logic [2:0] addr_bytes_for(input logic [7:0] plen);
        logic [2:0] n;
        if (plen > 8'd24) begin
            n = 3'd4;
        end else if (plen > 8'd16) begin
            n = 3'd3;
        end else if (plen > 8'd8) begin
            n = 3'd2;
        end else if (plen > 8'd0) begin
            n = 3'd1;
        end else begin
            n = 3'd0;
        end
        return n;
    endfunction

endpackage

// File: hdl/bgp_message_prefix_counter.sv
// top level of the bgp message prefix counter
//
// input channel: one byte of the received bgp stream per request
// (i_valid / o_ready / i_stream_byte); the marker is not checked
// output channel: one request per message (o_valid / i_ready) carrying
// type, total length, nlri prefix count, end-of-rib flag and status
// a message with a bad length reports at its type byte, every other
// message reports at its last byte
// a byte waits in the input register and is parsed as it leaves it; its
// result, if any, is loaded into the result register at that step
// throughput: one byte per cycle unless the receiver stalls; the parser
// state is a handful of counters and a phase register updated once per byte
// reset (synchronous, active low) empties both registers and puts the
// parser at the start of a marker
// a stalled receiver holds the result register; the parser waits on it,
// the input register keeps one byte, and o_ready falls once it is full
module bgp_message_prefix_counter
    import bmpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_stream_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_message_type,
    output logic [15:0] o_message_length,
    output logic [12:0] o_prefix_total,
    output logic        o_end_of_rib,
    output logic [1:0]  o_status
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_free;
    logic       step;
    logic       emit;
    t_result    result;
    t_result    out_result;

    // parse a byte only when the result register can take what it makes
    assign step = in_valid && out_free;

    bmpc_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_stream_byte (i_stream_byte),
        .i_take        (step),
        .o_ready       (o_ready),
        .o_valid       (in_valid),
        .o_byte        (in_byte)
    );

    bmpc_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (in_byte),
        .o_emit   (emit),
        .o_result (result)
    );

    bmpc_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step && emit),
        .i_result (result),
        .i_ready  (i_ready),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    // unpack the result register onto the field ports
    assign o_message_type   = out_result.message_type;
    assign o_message_length = out_result.message_length;
    assign o_prefix_total   = out_result.prefix_total;
    assign o_end_of_rib     = out_result.end_of_rib;
    assign o_status         = out_result.status;

endmodule

// File: hdl/bmpc_in_stage.sv
// input register holding one stream byte for the parser
module bmpc_in_stage
    import bmpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_stream_byte,
    input  logic       i_take,
    output logic       o_ready,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_stream_byte;
        end
    end

endmodule

// File: hdl/bmpc_parser.sv
// message framing, update walk and prefix counting, one byte per step
module bmpc_parser
    import bmpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output logic       o_emit,
    output t_result    o_result
);

    t_phase      r_phase,   n_phase;
    logic [15:0] r_pos,     n_pos;
    logic [15:0] r_len,     n_len;
    logic [7:0]  r_type,    n_type;
    logic [15:0] r_sec,     n_sec;
    logic [12:0] r_tally,   n_tally;
    logic [2:0]  r_abl,     n_abl;
    logic        r_ovr,     n_ovr;

    logic        v_end_chk;
    logic        v_upd;

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_len    = r_len;
        n_type   = r_type;
        n_sec    = r_sec;
        n_tally  = r_tally;
        n_abl    = r_abl;
        n_ovr    = r_ovr;
        o_emit   = 1'b0;
        o_result = '0;
        v_end_chk = 1'b0;
        v_upd     = 1'b0;

        if (i_step) begin
            v_end_chk = 1'b1;
            case (r_phase)
                PH_HEADER: begin
                    if (r_pos == LEN_HI_POS) begin
                        n_len = {i_byte, 8'h00};
                    end else if (r_pos == LEN_LO_POS) begin
                        n_len = r_len | {8'h00, i_byte};
                    end else if (r_pos == TYPE_POS) begin
                        n_type = i_byte;
                    end
                    if (r_pos < TYPE_POS) begin
                        n_pos     = r_pos + 16'd1;
                        v_end_chk = 1'b0;
                    end else if (n_len < MIN_LEN || n_len > MAX_LEN) begin
                        // bad length beats illegal type, next byte starts a marker
                        o_emit                  = 1'b1;
                        o_result.message_type   = n_type;
                        o_result.message_length = n_len;
                        o_result.status         = ST_BAD_LENGTH;
                        n_phase   = PH_HEADER;
                        n_pos     = 16'd0;
                        v_end_chk = 1'b0;
                    end else begin
                        n_tally = '0;
                        n_ovr   = 1'b0;
                        n_abl   = '0;
                        n_sec   = '0;
                        n_phase = (n_type == TYPE_UPDATE) ? PH_WLEN : PH_SKIP;
                    end
                end
                PH_WLEN, PH_PLEN: begin
                    if (r_abl == 3'd0) begin
                        n_sec = {i_byte, 8'h00};
                        n_abl = 3'd1;
                    end else begin
                        n_sec = r_sec | {8'h00, i_byte};
                        n_abl = 3'd0;
                        if (r_phase == PH_WLEN) begin
                            n_phase = (n_sec != 16'd0) ? PH_WSKIP : PH_PLEN;
                        end else begin
                            n_phase = (n_sec != 16'd0) ? PH_PSKIP : PH_NLRI;
                        end
                    end
                end
                PH_WSKIP, PH_PSKIP: begin
                    n_sec = r_sec - 16'd1;
                    if (n_sec == 16'd0) begin
                        n_phase = (r_phase == PH_WSKIP) ? PH_PLEN : PH_NLRI;
                    end
                end
                PH_NLRI: begin
                    if (r_abl != 3'd0) begin
                        n_abl = r_abl - 3'd1;
                    end else begin
                        n_abl = addr_bytes_for(i_byte);
                        if (r_tally < TALLY_MAX) begin
                            n_tally = r_tally + 13'd1;
                        end
                    end
                end
                default: begin
                    // body of a non-update message, byte ignored
                end
            endcase

            if (v_end_chk) begin
                if (({1'b0, r_pos} + 17'd1) == {1'b0, n_len}) begin
                    v_upd                   = (n_type == TYPE_UPDATE);
                    o_emit                  = 1'b1;
                    o_result.message_type   = n_type;
                    o_result.message_length = n_len;
                    o_result.prefix_total   = v_upd ? n_tally : 13'd0;
                    o_result.end_of_rib     = v_upd && (n_len == EOR_LEN);
                    if (!(n_type inside {[TYPE_MIN:TYPE_MAX]})) begin
                        o_result.status = ST_ILLEGAL_TYPE;
                    end else if (v_upd && (n_phase != PH_NLRI || n_abl != 3'd0)) begin
                        n_ovr           = 1'b1;
                        o_result.status = ST_OVERRUN;
                    end else begin
                        o_result.status = ST_OK;
                    end
                    n_phase = PH_HEADER;
                    n_pos   = 16'd0;
                    n_abl   = 3'd0;
                end else begin
                    n_pos = r_pos + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_len   <= '0;
            r_type  <= '0;
            r_sec   <= '0;
            r_tally <= '0;
            r_abl   <= '0;
            r_ovr   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_type  <= n_type;
            r_sec   <= n_sec;
            r_tally <= n_tally;
            r_abl   <= n_abl;
            r_ovr   <= n_ovr;
        end
    end

endmodule

// File: hdl/bmpc_out_stage.sv
// result register toward the receiver
module bmpc_out_stage
    import bmpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// File: hdl/bmpc_checker.sv
// port-level checks for the bgp message prefix counter, bound to the top
`include "bgp_message_prefix_counter_macros.svh"

module bmpc_checker
    import bmpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [7:0]  i_stream_byte,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [7:0]  o_message_type,
    input  logic [15:0] o_message_length,
    input  logic [12:0] o_prefix_total,
    input  logic        o_end_of_rib,
    input  logic [1:0]  o_status
);

    `BMPC_ASSERT_NEXT(a_in_hold, i_valid && !o_ready, i_valid && $stable(i_stream_byte), "request changed while waiting")
    `BMPC_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_message_length) && $stable(o_status), "result changed while stalled")
    `BMPC_ASSERT_NOW(a_eor_shape, o_valid && o_end_of_rib, o_message_type == TYPE_UPDATE && o_message_length == EOR_LEN, "end of rib on a message that is not an empty update")
    `BMPC_ASSERT_NOW(a_bad_len_empty, o_valid && o_status == ST_BAD_LENGTH, o_prefix_total == 13'd0 && !o_end_of_rib && (o_message_length < MIN_LEN || o_message_length > MAX_LEN), "bad length result malformed")
    `BMPC_ASSERT_NOW(a_good_len_range, o_valid && o_status != ST_BAD_LENGTH, o_message_length >= MIN_LEN && o_message_length <= MAX_LEN, "accepted message length out of range")

endmodule

bind bgp_message_prefix_counter bmpc_checker u_checker (.*);

// File: dv/tb_bgp_message_prefix_counter.sv
// testbench for the bgp message prefix counter: framed byte stream in, checked reports out
`timescale 1ns / 100ps

module tb_bgp_message_prefix_counter;
    import bmpc_pkg::*;

    localparam int RANDOM_BYTES = 620;
    localparam int REPORT_LIMIT = 10;

    // one message to put on the stream
    typedef struct {
        logic [7:0]  type_code;
        int          hdr_len;      // length field, -1 takes the natural length
        int          len_adj;      // added to the natural length
        logic [15:0] wdr_len;
        logic [15:0] attr_len;     // attribute length for updates, body size for other types
        int          n_prefix;
        logic [63:0] prefix_lens;  // byte i holds prefix length i
        int          pad;          // filler past the natural body, -1 random
        bit          has_exp;
        t_result     exp_report;
    } t_msg_spec;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_stream_byte;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_message_type;
    logic [15:0] o_message_length;
    logic [12:0] o_prefix_total;
    logic        o_end_of_rib;
    logic [1:0]  o_status;

    // parser state of the predictor
    t_phase      fr_phase;
    logic [15:0] fr_pos;
    logic [15:0] fr_len;
    logic [7:0]  fr_type;
    logic [15:0] fr_remaining;
    logic [12:0] fr_tally;
    logic [2:0]  fr_addr_left;

    t_result     pending_reports[$];
    t_msg_spec   directed_rows[$];
    bit          override_armed;
    t_result     override_val;
    int          idle_pct;
    int          stall_pct;
    int          bytes_sent;
    int          msgs_sent;
    int          random_msgs;
    int          errors;
    int          status_count[4];

    bgp_message_prefix_counter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_stream_byte    (i_stream_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_message_type   (o_message_type),
        .o_message_length (o_message_length),
        .o_prefix_total   (o_prefix_total),
        .o_end_of_rib     (o_end_of_rib),
        .o_status         (o_status)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [2:0] address_span(input logic [7:0] plen);
        int n;
        n = (plen > 8'd0) + (plen > 8'd8) + (plen > 8'd16) + (plen > 8'd24);
        return n[2:0];
    endfunction

    // big-endian section length, high byte first; fr_addr_left marks the half
    function automatic bit take_length_byte(input logic [7:0] b);
        if (fr_addr_left == 3'd0) begin
            fr_remaining = {b, 8'h00};
            fr_addr_left = 3'd1;
            return 1'b0;
        end
        fr_remaining = fr_remaining | {8'h00, b};
        fr_addr_left = 3'd0;
        return 1'b1;
    endfunction

    // advance the predicted parser by one stream byte; 1 when a report is due
    function automatic bit frame_byte(input logic [7:0] b, output t_result r);
        logic [15:0] pos;
        bit          upd;
        pos = fr_pos;
        r = '0;
        case (fr_phase)
            PH_HEADER: begin
                if (pos == LEN_HI_POS) fr_len = {b, 8'h00};
                else if (pos == LEN_LO_POS) fr_len = fr_len | {8'h00, b};
                else if (pos == TYPE_POS) fr_type = b;
                if (pos < TYPE_POS) begin
                    fr_pos = pos + 16'd1;
                    return 1'b0;
                end
                if (fr_len < MIN_LEN || fr_len > MAX_LEN) begin
                    r.message_type = fr_type;
                    r.message_length = fr_len;
                    r.status = ST_BAD_LENGTH;
                    fr_phase = PH_HEADER;
                    fr_pos = '0;
                    return 1'b1;
                end
                fr_tally = '0;
                fr_addr_left = '0;
                fr_remaining = '0;
                fr_phase = (fr_type == TYPE_UPDATE) ? PH_WLEN : PH_SKIP;
            end
            PH_WLEN: begin
                if (take_length_byte(b)) fr_phase = (fr_remaining != 0) ? PH_WSKIP : PH_PLEN;
            end
            PH_WSKIP: begin
                fr_remaining = fr_remaining - 16'd1;
                if (fr_remaining == 0) fr_phase = PH_PLEN;
            end
            PH_PLEN: begin
                if (take_length_byte(b)) fr_phase = (fr_remaining != 0) ? PH_PSKIP : PH_NLRI;
            end
            PH_PSKIP: begin
                fr_remaining = fr_remaining - 16'd1;
                if (fr_remaining == 0) fr_phase = PH_NLRI;
            end
            PH_NLRI: begin
                if (fr_addr_left != 0) begin
                    fr_addr_left = fr_addr_left - 3'd1;
                end else begin
                    fr_addr_left = address_span(b);
                    if (fr_tally < TALLY_MAX) fr_tally = fr_tally + 13'd1;
                end
            end
            default: ;
        endcase
        if (({1'b0, pos} + 17'd1) == {1'b0, fr_len}) begin
            upd = (fr_type == TYPE_UPDATE);
            r.message_type = fr_type;
            r.message_length = fr_len;
            r.prefix_total = upd ? fr_tally : 13'd0;
            r.end_of_rib = upd && (fr_len == EOR_LEN);
            if (fr_type < TYPE_MIN || fr_type > TYPE_MAX) r.status = ST_ILLEGAL_TYPE;
            else if (upd && (fr_phase != PH_NLRI || fr_addr_left != 0)) r.status = ST_OVERRUN;
            else r.status = ST_OK;
            fr_phase = PH_HEADER;
            fr_pos = '0;
            fr_addr_left = '0;
            return 1'b1;
        end
        fr_pos = pos + 16'd1;
        return 1'b0;
    endfunction

    function automatic t_msg_spec message_spec(input logic [7:0] type_code, input int hdr_len,
                                               input int len_adj, input logic [15:0] wdr_len,
                                               input logic [15:0] attr_len, input int n_prefix,
                                               input logic [63:0] prefix_lens, input int pad,
                                               input bit has_exp, input t_result exp_report);
        t_msg_spec s;
        s.type_code = type_code;
        s.hdr_len = hdr_len;
        s.len_adj = len_adj;
        s.wdr_len = wdr_len;
        s.attr_len = attr_len;
        s.n_prefix = n_prefix;
        s.prefix_lens = prefix_lens;
        s.pad = pad;
        s.has_exp = has_exp;
        s.exp_report = exp_report;
        return s;
    endfunction

    // mostly well-formed updates, the rest other types, bad headers and cut or padded updates
    function automatic t_msg_spec random_spec();
        t_msg_spec s;
        int        k;
        int        i;
        k = $urandom_range(99);
        s = message_spec(TYPE_UPDATE, -1, 0, '0, '0, 0, '0, -1, 1'b0, '0);
        s.wdr_len = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(6));
        s.attr_len = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(10));
        s.n_prefix = $urandom_range(6);
        for (i = 0; i < 8; i++) begin
            s.prefix_lens[8*i +: 8] = 8'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                                   : $urandom_range(32));
        end
        if (k < 62) begin
            // well-formed update, fields above stand
        end else if (k < 72) begin
            case ($urandom_range(2))
                0: s.type_code = 8'd1;
                1: s.type_code = 8'd3;
                default: s.type_code = TYPE_MAX;
            endcase
            s.attr_len = 16'($urandom_range(20));
        end else if (k < 78) begin
            s.type_code = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255, 5));
            s.attr_len = 16'($urandom_range(10));
        end else if (k < 85) begin
            s.type_code = 8'($urandom_range(255));
            s.hdr_len = ($urandom_range(1) == 0) ? $urandom_range(18)
                                                 : $urandom_range(65535, MAX_LEN + 1);
        end else if (k < 96) begin
            s.len_adj = $urandom_range(12) - 6;
        end else if (k < 99) begin
            s.attr_len = 16'($urandom_range(300, 256));
        end else begin
            s.type_code = 8'($urandom_range(4, 1));
            s.hdr_len = $urandom_range(120, 40);
        end
        return s;
    endfunction

    // one request on the input channel; the predictor runs on acceptance
    task automatic send_byte(input logic [7:0] b);
        t_result r;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_stream_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        bytes_sent++;
        if (frame_byte(b, r)) begin
            if (override_armed) begin
                r = override_val;
                override_armed = 1'b0;
            end
            pending_reports.push_back(r);
        end
        @(negedge i_clk);
    endtask

    task automatic send_message(input t_msg_spec s);
        logic [7:0]  body[$];
        logic [7:0]  plen;
        logic [15:0] len_field;
        int          total;
        int          i;
        if (s.type_code == TYPE_UPDATE) begin
            body.push_back(s.wdr_len[15:8]);
            body.push_back(s.wdr_len[7:0]);
            repeat (s.wdr_len) body.push_back(8'($urandom_range(255)));
            body.push_back(s.attr_len[15:8]);
            body.push_back(s.attr_len[7:0]);
            repeat (s.attr_len) body.push_back(8'($urandom_range(255)));
            for (i = 0; i < s.n_prefix; i++) begin
                plen = s.prefix_lens[8*i +: 8];
                body.push_back(plen);
                repeat (address_span(plen)) body.push_back(8'($urandom_range(255)));
            end
        end else begin
            repeat (s.attr_len) body.push_back(8'($urandom_range(255)));
        end
        if (s.hdr_len < 0) begin
            total = 19 + body.size() + s.len_adj;
            if (total < 19) total = 19;
        end else begin
            total = s.hdr_len;
        end
        len_field = total[15:0];
        override_armed = s.has_exp;
        override_val = s.exp_report;
        msgs_sent++;
        // marker is not checked, so any content will do
        repeat (16) send_byte(8'($urandom_range(255)));
        send_byte(len_field[15:8]);
        send_byte(len_field[7:0]);
        send_byte(s.type_code);
        if (len_field >= MIN_LEN && len_field <= MAX_LEN) begin
            for (i = 0; i < total - 19; i++) begin
                if (i < body.size()) send_byte(body[i]);
                else if (s.pad < 0) send_byte(8'($urandom_range(255)));
                else send_byte(s.pad[7:0]);
            end
        end
    endtask

    // receiver back-pressure, changed on the falling edge
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin : report_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            status_count[o_status]++;
            if (pending_reports.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("unexpected report: type %0d len %0d pfx %0d eor %0d st %0d",
                             o_message_type, o_message_length, o_prefix_total,
                             o_end_of_rib, o_status);
                end
            end else begin
                want = pending_reports.pop_front();
                if (o_message_type !== want.message_type
                        || o_message_length !== want.message_length
                        || o_prefix_total !== want.prefix_total
                        || o_end_of_rib !== want.end_of_rib
                        || o_status !== want.status) begin
                    errors++;
                    if (errors <= REPORT_LIMIT) begin
                        $display("report mismatch at %0t", $realtime);
                        $display("  expected type %0d len %0d pfx %0d eor %0d st %0d",
                                 want.message_type, want.message_length, want.prefix_total,
                                 want.end_of_rib, want.status);
                        $display("  actual   type %0d len %0d pfx %0d eor %0d st %0d",
                                 o_message_type, o_message_length, o_prefix_total,
                                 o_end_of_rib, o_status);
                    end
                end
            end
        end
    end

    initial begin
        int start_bytes;
        int guard;
        int phase_sel;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stream_byte = '0;
        i_ready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        errors = 0;
        bytes_sent = 0;
        msgs_sent = 0;
        random_msgs = 0;
        override_armed = 1'b0;
        fr_phase = PH_HEADER;
        fr_pos = '0;
        fr_len = '0;
        fr_type = '0;
        fr_remaining = '0;
        fr_tally = '0;
        fr_addr_left = '0;

        // type, length (-1 natural), adjust, withdrawn, attributes/body, prefixes, lengths,
        // pad, then a typed report where it is obvious
        directed_rows.push_back(message_spec(TYPE_MAX, -1, 0, 16'd0, 16'd0, 0, '0, -1,
                                1'b1, {TYPE_MAX, MIN_LEN, 13'd0, 1'b0, ST_OK}));
        directed_rows.push_back(message_spec(TYPE_UPDATE, -1, 0, 16'd0, 16'd0, 0, '0, -1,
                                1'b1, {TYPE_UPDATE, EOR_LEN, 13'd0, 1'b1, ST_OK}));
        // update cut off at its type byte
        directed_rows.push_back(message_spec(TYPE_UPDATE, 19, 0, 16'd0, 16'd0, 0, '0, -1,
                                1'b1, {TYPE_UPDATE, MIN_LEN, 13'd0, 1'b0, ST_OVERRUN}));
        directed_rows.push_back(message_spec(TYPE_UPDATE, 18, 0, 16'd0, 16'd0, 0, '0, -1,
                                1'b1, {TYPE_UPDATE, 16'd18, 13'd0, 1'b0, ST_BAD_LENGTH}));
        // bad length wins over a bad type
        directed_rows.push_back(message_spec(8'd0, 0, 0, 16'd0, 16'd0, 0, '0, -1,
                                1'b1, {8'd0, 16'd0, 13'd0, 1'b0, ST_BAD_LENGTH}));
        directed_rows.push_back(message_spec(TYPE_MIN, 4097, 0, 16'd0, 16'd0, 0, '0, -1,
                                1'b1, {TYPE_MIN, 16'd4097, 13'd0, 1'b0, ST_BAD_LENGTH}));
        directed_rows.push_back(message_spec(8'd255, 65535, 0, 16'd0, 16'd0, 0, '0, -1,
                                1'b1, {8'd255, 16'd65535, 13'd0, 1'b0, ST_BAD_LENGTH}));
        directed_rows.push_back(message_spec(8'd0, -1, 0, 16'd0, 16'd6, 0, '0, -1,
                                1'b1, {8'd0, 16'd25, 13'd0, 1'b0, ST_ILLEGAL_TYPE}));
        directed_rows.push_back(message_spec(8'd5, -1, 0, 16'd0, 16'd3, 0, '0, -1,
                                1'b1, {8'd5, 16'd22, 13'd0, 1'b0, ST_ILLEGAL_TYPE}));
        directed_rows.push_back(message_spec(8'd255, 19, 0, 16'd0, 16'd0, 0, '0, -1,
                                1'b1, {8'd255, MIN_LEN, 13'd0, 1'b0, ST_ILLEGAL_TYPE}));
        directed_rows.push_back(message_spec(TYPE_MIN, -1, 0, 16'd0, 16'd10, 0, '0, -1,
                                1'b1, {TYPE_MIN, 16'd29, 13'd0, 1'b0, ST_OK}));
        directed_rows.push_back(message_spec(8'd3, -1, 0, 16'd0, 16'd2, 0, '0, -1,
                                1'b1, {8'd3, 16'd21, 13'd0, 1'b0, ST_OK}));
        // every address-byte threshold
        directed_rows.push_back(message_spec(TYPE_UPDATE, -1, 0, 16'd0, 16'd0, 8,
                                {8'd32, 8'd25, 8'd24, 8'd17, 8'd16, 8'd9, 8'd8, 8'd0},
                                -1, 1'b0, '0));
        directed_rows.push_back(message_spec(TYPE_UPDATE, -1, 0, 16'd5, 16'd7, 3,
                                {40'd0, 8'd1, 8'd33, 8'd255}, -1, 1'b0, '0));
        directed_rows.push_back(message_spec(TYPE_UPDATE, -1, 0, 16'd0, 16'd256, 2,
                                {48'd0, 8'd20, 8'd12}, -1, 1'b0, '0));
        // truncated inside withdrawn length, withdrawn routes, attribute length,
        // attributes and prefix address
        directed_rows.push_back(message_spec(TYPE_UPDATE, -1, -3, 16'd0, 16'd0, 0, '0, -1,
                                1'b0, '0));
        directed_rows.push_back(message_spec(TYPE_UPDATE, -1, -9, 16'd10, 16'd0, 0, '0, -1,
                                1'b0, '0));
        directed_rows.push_back(message_spec(TYPE_UPDATE, -1, -1, 16'd0, 16'd0, 0, '0, -1,
                                1'b0, '0));
        directed_rows.push_back(message_spec(TYPE_UPDATE, -1, -4, 16'd0, 16'd8, 0, '0, -1,
                                1'b0, '0));
        directed_rows.push_back(message_spec(TYPE_UPDATE, -1, -2, 16'd0, 16'd0, 1, 64'd32, -1,
                                1'b0, '0));
        // trailing filler parsed as more nlri
        directed_rows.push_back(message_spec(TYPE_UPDATE, -1, 5, 16'd1, 16'd1, 2,
                                {48'd0, 8'd7, 8'd30}, -1, 1'b0, '0));
        // update padded out with zero-length prefixes, each one counted
        directed_rows.push_back(message_spec(TYPE_UPDATE, 100, 0, 16'd0, 16'd0, 0, '0, 0,
                                1'b0, '0));
        directed_rows.push_back(message_spec(8'd7, 40, 0, 16'd0, 16'd0, 0, '0, -1,
                                1'b1, {8'd7, 16'd40, 13'd0, 1'b0, ST_ILLEGAL_TYPE}));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) send_message(directed_rows[k]);

        // four pacing mixes over the random stream
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            phase_sel = (bytes_sent - start_bytes) * 4 / RANDOM_BYTES;
            case (phase_sel)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 54; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 54; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            send_message(random_spec());
            random_msgs++;
        end
        i_valid <= 1'b0;

        guard = 0;
        while (pending_reports.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        // input and result registers in the path; give them spare edges for stray reports
        repeat (8) @(posedge i_clk);
        if (pending_reports.size() != 0) begin
            $display("%0d expected reports never arrived", pending_reports.size());
            errors++;
        end

        $display("streamed %0d bytes as %0d messages (%0d random) under four pacing mixes",
                 bytes_sent, msgs_sent, random_msgs);
        $display("reports: %0d ok, %0d illegal type, %0d bad length, %0d overrun; %0d errors",
                 status_count[ST_OK], status_count[ST_ILLEGAL_TYPE],
                 status_count[ST_BAD_LENGTH], status_count[ST_OVERRUN], errors);
        if (errors == 0) begin
            $display("tb_bgp_message_prefix_counter: clean");
        end else begin
            $display("tb_bgp_message_prefix_counter: errors");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout waiting on the block");
        $display("tb_bgp_message_prefix_counter: errors");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/bmpc_pkg.sv
hdl/bmpc_in_stage.sv
hdl/bmpc_parser.sv
hdl/bmpc_out_stage.sv
hdl/bgp_message_prefix_counter.sv
hdl/bmpc_checker.sv
dv/tb_bgp_message_prefix_counter.sv
